// ===== rtl/lhc_pkg.sv =====
// shared constants, codes and types of the heading cone obstacle check
// no dependencies
package lhc_pkg;

	localparam int unsigned MAX_SAMPLES  = 2048;
	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned ATAN_LEN     = 24;
	localparam int unsigned CORD_N       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int unsigned IDX_W        = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned CW           = 27;
	localparam int unsigned DVD_W        = 24;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned CFG_IDX_W    = 1;

	localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORD_N - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DVD_W - 1);
	localparam logic [IDX_W-1:0] MAX_IDX   = IDX_W'(MAX_SAMPLES);
	localparam logic [15:0]      CONE_HALF = 16'd8192;
	localparam logic [15:0]      THR_RESET  = 16'd400;
	localparam logic [23:0]      STEP_RESET = 24'd46603;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 1'b0,
		REG_ANGLE_STEP = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_HEAD,
		ST_DIV_LD0,
		ST_DIV_RUN0,
		ST_DIV_LD1,
		ST_DIV_RUN1,
		ST_WIN_END,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic             vel_load;
		logic             hold_load;
		logic             cordic_init;
		logic             cordic_step;
		logic             head_load;
		logic             div_load;
		logic             div_sel_end;
		logic             div_step;
		logic             win_start_st;
		logic             win_end_st;
		logic             sample_go;
		logic             use_held;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic vel_large;
		logic pos_zero;
		logic out_free;
		logic held_last;
	} sts_t;

	function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2F9;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/lidar_heading_cone_obstacle_check.sv =====
// Heading cone obstacle check over a stream of lidar range samples. A velocity
// item, or a range sample inside a scan, is taken straight from the idle state.
// The first range sample of a scan is held while the iterative cordic unit runs
// CORDIC_STEPS steps (skipped when the stored velocity is too small to move the
// heading) and the shared radix-2 divider then runs twice for the cone edges.
// A result waits in an output register while new items are taken; only a last
// sample that would need that register while it is still full is held off.
// Configuration is written through cfg_we, cfg_index and cfg_data. Uses lhc_pkg,
// lhc_ctrl and lhc_dp.
module lidar_heading_cone_obstacle_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic signed [15:0]            vel_x,
	input  logic signed [15:0]            vel_y,
	input  logic [15:0]                   range_mm,
	input  logic                          range_valid,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          obst_flag,
	input  logic                          cfg_we,
	input  logic [lhc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]                   cfg_data
);

	lhc_pkg::cmd_t cmd;
	lhc_pkg::sts_t sts;

	lhc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.last_sample (last_sample),
		.sts         (sts),
		.cmd         (cmd)
	);

	lhc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.range_mm    (range_mm),
		.range_valid (range_valid),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.obst_flag   (obst_flag)
	);

endmodule

// ===== rtl/lhc_dp.sv =====
// datapath: config registers, velocity store, iterative cordic, shared divider,
// cone window and scan state, output register; uses lhc_pkg
module lhc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lhc_pkg::cmd_t                    cmd,
	output lhc_pkg::sts_t                    sts,
	input  logic                             cfg_we,
	input  logic [lhc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [23:0]                      cfg_data,
	input  logic signed [15:0]               vel_x,
	input  logic signed [15:0]               vel_y,
	input  logic [15:0]                      range_mm,
	input  logic                             range_valid,
	input  logic                             last_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             obst_flag
);

	logic [15:0]                       thr_q;
	logic [23:0]                       step_q;
	logic signed [15:0]                vel_x_q;
	logic signed [15:0]                vel_y_q;
	logic [15:0]                       heading_q;
	logic [lhc_pkg::IDX_W-1:0]         pos_q;
	logic [lhc_pkg::IDX_W-1:0]         win_start_q;
	logic [lhc_pkg::IDX_W-1:0]         win_end_q;
	logic                              hit_q;
	logic [15:0]                       hold_range_q;
	logic                              hold_rv_q;
	logic                              hold_last_q;
	logic signed [lhc_pkg::CW-1:0]     x_q;
	logic signed [lhc_pkg::CW-1:0]     y_q;
	logic [31:0]                       z_q;
	logic [lhc_pkg::DVD_W-1:0]         dvd_q;
	logic [lhc_pkg::DVD_W-1:0]         rem_q;
	logic                              out_valid_q;
	logic                              det_q;

	logic signed [lhc_pkg::CW-1:0]     xi;
	logic signed [lhc_pkg::CW-1:0]     yi;
	logic signed [lhc_pkg::CW-1:0]     xs;
	logic signed [lhc_pkg::CW-1:0]     ys;
	logic [31:0]                       z_rnd;
	logic [15:0]                       edge_bau;
	logic [23:0]                       divisor;
	logic [lhc_pkg::DVD_W:0]           trial;
	logic [lhc_pkg::IDX_W-1:0]         q_idx;
	logic [15:0]                       s_range;
	logic                              s_rv;
	logic                              s_last;
	logic                              in_window;
	logic                              hit_new;
	logic                              out_free;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= lhc_pkg::THR_RESET;
			step_q <= lhc_pkg::STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lhc_pkg::REG_THRESHOLD:  thr_q  <= cfg_data[15:0];
				lhc_pkg::REG_ANGLE_STEP: step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// cordic
	assign xi    = lhc_pkg::CW'({{(lhc_pkg::CW-24){vel_x_q[15]}}, vel_x_q, 8'd0});
	assign yi    = lhc_pkg::CW'({{(lhc_pkg::CW-24){vel_y_q[15]}}, vel_y_q, 8'd0});
	assign xs    = x_q >>> cmd.step;
	assign ys    = y_q >>> cmd.step;
	assign z_rnd = z_q + 32'h00008000;

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			if (vel_x_q[15]) begin
				x_q <= -xi;
				y_q <= -yi;
				z_q <= 32'h80000000;
			end else begin
				x_q <= xi;
				y_q <= yi;
				z_q <= 32'h00000000;
			end
		end else if (cmd.cordic_step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + lhc_pkg::atan_entry(cmd.step);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - lhc_pkg::atan_entry(cmd.step);
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	assign edge_bau = cmd.div_sel_end ? heading_q + lhc_pkg::CONE_HALF
	                                  : heading_q - lhc_pkg::CONE_HALF;
	assign divisor  = (step_q == 24'd0) ? 24'd1 : step_q;
	assign trial    = {rem_q, dvd_q[lhc_pkg::DVD_W-1]} - {1'b0, divisor};
	assign q_idx    = (dvd_q > lhc_pkg::DVD_W'(lhc_pkg::MAX_SAMPLES)) ? lhc_pkg::MAX_IDX
	                                                                 : dvd_q[lhc_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= {edge_bau, 8'd0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[lhc_pkg::DVD_W]) begin
				rem_q <= trial[lhc_pkg::DVD_W-1:0];
				dvd_q <= {dvd_q[lhc_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[lhc_pkg::DVD_W-2:0], dvd_q[lhc_pkg::DVD_W-1]};
				dvd_q <= {dvd_q[lhc_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	// held sample of a scan start
	always_ff @(posedge clk) begin
		if (cmd.hold_load) begin
			hold_range_q <= range_mm;
			hold_rv_q    <= range_valid;
			hold_last_q  <= last_sample;
		end
	end

	// window check
	assign s_range = cmd.use_held ? hold_range_q : range_mm;
	assign s_rv    = cmd.use_held ? hold_rv_q : range_valid;
	assign s_last  = cmd.use_held ? hold_last_q : last_sample;

	always_comb begin
		if (pos_q >= lhc_pkg::MAX_IDX) begin
			in_window = 1'b0;
		end else if (win_start_q <= win_end_q) begin
			in_window = (pos_q >= win_start_q) && (pos_q < win_end_q);
		end else begin
			in_window = (pos_q >= win_start_q) || (pos_q < win_end_q);
		end
	end

	assign hit_new  = hit_q | (in_window & s_rv & (s_range < thr_q));
	assign out_free = !out_valid_q || out_ready;

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			heading_q   <= '0;
			pos_q       <= '0;
			win_start_q <= '0;
			win_end_q   <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (cmd.vel_load) begin
				vel_x_q <= vel_x;
				vel_y_q <= vel_y;
			end
			if (cmd.head_load) begin
				heading_q <= z_rnd[31:16];
			end
			if (cmd.win_start_st) begin
				win_start_q <= q_idx;
			end
			if (cmd.win_end_st) begin
				win_end_q <= q_idx;
			end
			if (cmd.sample_go) begin
				if (s_last) begin
					hit_q <= 1'b0;
					pos_q <= '0;
				end else begin
					hit_q <= hit_new;
					if (pos_q < lhc_pkg::MAX_IDX) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.sample_go && s_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample_go && s_last) begin
			det_q <= hit_new;
		end
	end

	assign out_valid = out_valid_q;
	assign obst_flag = det_q;

	assign sts.vel_large = (vel_x_q > 16'sd1) || (vel_x_q < -16'sd1) ||
	                       (vel_y_q > 16'sd1) || (vel_y_q < -16'sd1);
	assign sts.pos_zero  = (pos_q == '0);
	assign sts.out_free  = out_free;
	assign sts.held_last = hold_last_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= lhc_pkg::MAX_IDX)
		else $error("sample position beyond scan length");

	a_win_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(win_start_q <= lhc_pkg::MAX_IDX) && (win_end_q <= lhc_pkg::MAX_IDX))
		else $error("cone window index not clamped");

	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sample_go && s_last) |=> (pos_q == '0) && !hit_q && out_valid_q)
		else $error("last item did not restart the scan");

endmodule

// ===== rtl/lhc_ctrl.sv =====
// controller: sequences scan start (cordic when the velocity is large, two divisions) and sample items
// uses lhc_pkg
module lhc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          mode,
	input  logic          last_sample,
	input  lhc_pkg::sts_t sts,
	output lhc_pkg::cmd_t cmd
);

	lhc_pkg::state_t           state_q;
	lhc_pkg::state_t           state_d;
	logic [lhc_pkg::CNT_W-1:0] cnt_q;
	logic                      accept;
	logic                      emit_block;

	assign emit_block = sts.held_last && !sts.out_free;

	always_comb begin
		in_ready = 1'b0;
		if (state_q == lhc_pkg::ST_IDLE) begin
			in_ready = !(mode && last_sample && !sts.pos_zero && !sts.out_free);
		end
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lhc_pkg::ST_IDLE: begin
				if (accept && mode && sts.pos_zero) begin
					state_d = sts.vel_large ? lhc_pkg::ST_CORDIC : lhc_pkg::ST_DIV_LD0;
				end
			end
			lhc_pkg::ST_CORDIC: begin
				if (cnt_q == lhc_pkg::CORD_LAST) state_d = lhc_pkg::ST_HEAD;
			end
			lhc_pkg::ST_HEAD:     state_d = lhc_pkg::ST_DIV_LD0;
			lhc_pkg::ST_DIV_LD0:  state_d = lhc_pkg::ST_DIV_RUN0;
			lhc_pkg::ST_DIV_RUN0: begin
				if (cnt_q == lhc_pkg::DIV_LAST) state_d = lhc_pkg::ST_DIV_LD1;
			end
			lhc_pkg::ST_DIV_LD1:  state_d = lhc_pkg::ST_DIV_RUN1;
			lhc_pkg::ST_DIV_RUN1: begin
				if (cnt_q == lhc_pkg::DIV_LAST) state_d = lhc_pkg::ST_WIN_END;
			end
			lhc_pkg::ST_WIN_END:  state_d = lhc_pkg::ST_CHECK;
			lhc_pkg::ST_CHECK: begin
				if (!emit_block) state_d = lhc_pkg::ST_IDLE;
			end
			default:              state_d = lhc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.step = cnt_q;
		case (state_q)
			lhc_pkg::ST_IDLE: begin
				cmd.vel_load    = accept && !mode;
				cmd.hold_load   = accept && mode && sts.pos_zero;
				cmd.cordic_init = accept && mode && sts.pos_zero;
				cmd.sample_go   = accept && mode && !sts.pos_zero;
			end
			lhc_pkg::ST_CORDIC:   cmd.cordic_step = 1'b1;
			lhc_pkg::ST_HEAD:     cmd.head_load = 1'b1;
			lhc_pkg::ST_DIV_LD0:  cmd.div_load = 1'b1;
			lhc_pkg::ST_DIV_RUN0: cmd.div_step = 1'b1;
			lhc_pkg::ST_DIV_LD1: begin
				cmd.win_start_st = 1'b1;
				cmd.div_load     = 1'b1;
				cmd.div_sel_end  = 1'b1;
			end
			lhc_pkg::ST_DIV_RUN1: cmd.div_step = 1'b1;
			lhc_pkg::ST_WIN_END:  cmd.win_end_st = 1'b1;
			lhc_pkg::ST_CHECK: begin
				cmd.use_held  = 1'b1;
				cmd.sample_go = !emit_block;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lhc_pkg::ST_CORDIC || state_q == lhc_pkg::ST_DIV_RUN0 ||
			    state_q == lhc_pkg::ST_DIV_RUN1) begin
				cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == lhc_pkg::ST_IDLE))
		else $error("item taken while a scan start is in progress");

	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lhc_pkg::ST_CORDIC) |-> (cnt_q <= lhc_pkg::CORD_LAST))
		else $error("cordic step count overrun");

endmodule
